>>> rtl/core/lmp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Louvain local-moving pass core.
// No dependencies; used by lmp_muldiv and louvain_local_moving_pass_core.
package lmp_pkg;

	// Item kinds
	localparam logic [1:0] KIND_OFFSET = 2'd0;
	localparam logic [1:0] KIND_EDGE   = 2'd1;
	localparam logic [1:0] KIND_RUN    = 2'd2;
	localparam logic [1:0] KIND_LABEL  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_TOTAL_WT   = 2'd1;
	localparam logic [1:0] REG_MIN_IMP    = 2'd2;
	localparam logic [1:0] REG_WEIGHTED   = 2'd3;

	// Report kinds
	localparam logic RPT_PASS  = 1'b0;
	localparam logic RPT_LABEL = 1'b1;

	// Fixed field widths
	localparam int OFFW = 14;
	localparam int TGTW = 10;
	localparam int WGTW = 32;
	localparam int ACCW = 48;
	localparam int QW   = 34;

	localparam logic [WGTW-1:0] ONE_Q16  = 32'h0001_0000;
	localparam logic [63:0]     CAP_TOT2 = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0]     CAP_GAIN = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]     CAP_Q    = 64'h0000_0002_0000_0000;
	localparam logic [47:0]     SCALE_Q  = 48'h0001_0000_0000;
	localparam logic signed [QW-1:0] Q_MAX = 34'sh1_FFFF_FFFF;
	localparam logic signed [QW-1:0] Q_MIN = 34'sh2_0000_0000;

	// Main sequencer states
	typedef enum logic [4:0] {
		ST_IDLE, ST_LBL, ST_INIT, ST_SD_W,
		ST_EA, ST_EB, ST_EC, ST_EL, ST_ED, ST_GC, ST_GS,
		ST_CL_A, ST_CL_B, ST_OWN_A, ST_OWN_B, ST_RM_A, ST_RM_B,
		ST_EV_A, ST_EV_B, ST_EV_C, ST_EV_D, ST_INS_A, ST_INS_B,
		ST_SW, ST_MD_L, ST_MD_B, ST_MD_C, ST_MD_Q, ST_MD_R, ST_DONE
	} lmp_state_t;

	// Multiply-divide unit states
	typedef enum logic [2:0] {
		MDS_IDLE, MDS_MUL, MDS_CHK, MDS_DIV, MDS_FIN
	} md_state_t;

	// Request to the multiply-divide unit: floor(a*b/d), capped
	typedef struct packed {
		logic        go;
		logic [63:0] a;
		logic [47:0] b;
		logic [47:0] d;
		logic [63:0] cap;
	} md_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] q;
	} md_rsp_t;

endpackage

>>> rtl/core/lmp_muldiv.sv
`timescale 1ns / 1ps
// Shared shift-add multiplier and restoring divider: min(floor(a*b/d), cap).
// Depends on lmp_pkg.
module lmp_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  lmp_pkg::md_req_t req,
	output lmp_pkg::md_rsp_t rsp
);

	lmp_pkg::md_state_t st_q, st_d;
	logic [63:0] a_q, cap_q, acc_q, num_q, quo_q, q_q;
	logic [47:0] d_q, low_q, rem_q;
	logic [5:0]  cnt_q;
	logic        done_q;

	logic [64:0] msum;
	logic [48:0] dt, ddiff;
	logic        dge;
	logic [47:0] hi;

	// one multiply step and one divide step
	always_comb begin
		msum  = {1'b0, acc_q} + (low_q[0] ? {1'b0, a_q} : 65'd0);
		dt    = {rem_q, num_q[63]};
		dge   = dt >= {1'b0, d_q};
		ddiff = dt - {1'b0, d_q};
		hi    = acc_q[63:16];
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			lmp_pkg::MDS_IDLE: if (req.go) st_d = lmp_pkg::MDS_MUL;
			lmp_pkg::MDS_MUL:  if (cnt_q == 6'd47) st_d = lmp_pkg::MDS_CHK;
			lmp_pkg::MDS_CHK: begin
				if (hi >= d_q) st_d = lmp_pkg::MDS_FIN;
				else st_d = lmp_pkg::MDS_DIV;
			end
			lmp_pkg::MDS_DIV:  if (cnt_q == 6'd63) st_d = lmp_pkg::MDS_FIN;
			lmp_pkg::MDS_FIN:  st_d = lmp_pkg::MDS_IDLE;
			default:           st_d = lmp_pkg::MDS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.busy = st_q != lmp_pkg::MDS_IDLE;
		rsp.done = done_q;
		rsp.q    = q_q;
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= lmp_pkg::MDS_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= 1'b0;
			case (st_q)
				lmp_pkg::MDS_IDLE: begin
					if (req.go) begin
						a_q   <= req.a;
						d_q   <= req.d;
						cap_q <= req.cap;
						acc_q <= '0;
						low_q <= req.b;
						cnt_q <= '0;
					end
				end
				lmp_pkg::MDS_MUL: begin
					acc_q <= msum[64:1];
					low_q <= {msum[0], low_q[47:1]};
					cnt_q <= cnt_q + 6'd1;
				end
				lmp_pkg::MDS_CHK: begin
					// quotient overflows 64 bits: saturate
					quo_q <= cap_q;
					if (hi < d_q) begin
						quo_q <= '0;
						rem_q <= hi;
						num_q <= {acc_q[15:0], low_q};
						cnt_q <= '0;
					end
				end
				lmp_pkg::MDS_DIV: begin
					rem_q <= dge ? ddiff[47:0] : dt[47:0];
					num_q <= {num_q[62:0], 1'b0};
					quo_q <= {quo_q[62:0], dge};
					cnt_q <= cnt_q + 6'd1;
				end
				lmp_pkg::MDS_FIN: begin
					q_q    <= (quo_q < cap_q) ? quo_q : cap_q;
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/louvain_local_moving_pass_core.sv
`timescale 1ns / 1ps
// Louvain local-moving pass core: CSR graph store, sequencer and memories.
// Depends on lmp_pkg and lmp_muldiv.
//
//  channel   handshake           payload
//  input     start / busy        kind, slot, offset_value, neighbor, edge_weight
//  result    done (1 cycle)      report_kind, label, moves_last_sweep, sweeps,
//                                improvement, sweep_limit_hit
//  config    cfg_we              cfg_index, cfg_wdata
//
// Offset and edge loads are written when taken; a label read answers through the
// community read register, then the result register. A run clears MAX_NODES
// entries, walks the edges of each node, and uses the shared 48-step multiply
// and 64-step divide unit per community candidate and per modularity-sum term.
// Reset is asynchronous, active low; graph memories hold no reset value.
// busy is high for the whole run; results cannot be stalled.
module louvain_local_moving_pass_core #(
	parameter int MAX_NODES  = 1024,
	parameter int MAX_EDGES  = 8192,
	parameter int MAX_SWEEPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [12:0]        slot,
	input  logic [13:0]        offset_value,
	input  logic [9:0]         neighbor,
	input  logic [31:0]        edge_weight,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_wdata,
	output logic               done,
	output logic               report_kind,
	output logic [9:0]         label,
	output logic [10:0]        moves_last_sweep,
	output logic [6:0]         sweeps,
	output logic signed [33:0] improvement,
	output logic               sweep_limit_hit
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int ECW = (EW + 1 > lmp_pkg::OFFW) ? EW + 1 : lmp_pkg::OFFW;
	localparam int SWW = $clog2(MAX_SWEEPS + 1);

	// configuration
	logic [10:0] node_count_q;
	logic [47:0] total_wt_q;
	logic [31:0] min_imp_q;
	logic        weighted_q;

	// memories
	logic [lmp_pkg::OFFW-1:0] off_mem  [MAX_NODES+1];
	logic [lmp_pkg::TGTW-1:0] tgt_mem  [MAX_EDGES];
	logic [lmp_pkg::WGTW-1:0] wgt_mem  [MAX_EDGES];
	logic [NW-1:0]            comm_mem [MAX_NODES];
	logic [47:0]              cin_mem  [MAX_NODES];
	logic [47:0]              ctot_mem [MAX_NODES];
	logic [47:0]              deg_mem  [MAX_NODES];
	logic [31:0]              self_mem [MAX_NODES];
	logic [47:0]              nw_mem   [MAX_NODES];
	logic                     seen_mem [MAX_NODES];
	logic [NW-1:0]            list_mem [MAX_NODES];

	logic [lmp_pkg::OFFW-1:0] off_rd, off_wd;
	logic [NCW-1:0]           off_ra, off_wa;
	logic                     off_we;
	logic [lmp_pkg::TGTW-1:0] tgt_rd;
	logic [lmp_pkg::WGTW-1:0] wgt_rd;
	logic [EW-1:0]            edg_ra, edg_wa;
	logic                     edg_we;
	logic [NW-1:0]            comm_rd, comm_ra, comm_wa, comm_wd;
	logic                     comm_we;
	logic [47:0]              cin_rd, cin_wd, ctot_rd, ctot_wd;
	logic [NW-1:0]            cin_ra, cin_wa, ctot_ra, ctot_wa;
	logic                     cin_we, ctot_we;
	logic [47:0]              deg_rd;
	logic [31:0]              self_rd;
	logic                     ds_we;
	logic [47:0]              nw_rd, nw_wd;
	logic [NW-1:0]            nw_ra, nw_wa;
	logic                     nw_we;
	logic                     seen_rd, seen_wd, seen_we;
	logic [NW-1:0]            seen_ra, seen_wa;
	logic [NW-1:0]            list_rd, list_ra, list_wa, list_wd;
	logic                     list_we;

	// sequencer registers
	lmp_pkg::lmp_state_t state_q, state_d;
	logic [NCW-1:0] i_q, k_q, cnt_q, moves_q;
	logic [ECW-1:0] e_q, end_q;
	logic [SWW-1:0] sw_q;
	logic           gather_q, found_q, phase_q, limit_q, ran_q, lbl_ok_q;
	logic [47:0]    deg_q, bw_q, nwc_q, cin_q;
	logic [31:0]    self_q, w_q;
	logic [NW-1:0]  own_q, c_q, best_q;
	logic signed [64:0] bg_q;
	logic [63:0]    s_q;
	logic signed [lmp_pkg::QW-1:0] qstart_q, qnow_q, qcur_q;
	logic [9:0]     lbl_slot_q;

	// result registers
	logic               done_q, rkind_q, limit_out_q;
	logic [9:0]         label_q;
	logic [10:0]        moves_out_q;
	logic [6:0]         sweeps_out_q;
	logic signed [33:0] imp_q;

	lmp_pkg::md_req_t md_req;
	lmp_pkg::md_rsp_t md_rsp;

	// derived values
	logic               accept;
	logic [NCW-1:0]     n_eff;
	logic [47:0]        m2;
	logic [31:0]        wv;
	logic               t_in, t_self, last_node, last_init;
	logic [63:0]        mag;
	logic signed [64:0] gain;
	logic signed [lmp_pkg::QW-1:0] qv;
	logic signed [35:0] dq;
	logic               cont;
	logic [SWW-1:0]     sw_n;
	logic signed [34:0] impd;
	logic [ECW-1:0]     off_clip;

	assign accept = start && !busy;
	assign busy   = state_q != lmp_pkg::ST_IDLE;

	always_comb begin
		if (node_count_q == 11'd0) n_eff = NCW'(1);
		else if (32'(node_count_q) > MAX_NODES) n_eff = NCW'(MAX_NODES);
		else n_eff = NCW'(node_count_q);
		m2        = (total_wt_q == 48'd0) ? 48'd1 : total_wt_q;
		wv        = weighted_q ? wgt_rd : lmp_pkg::ONE_Q16;
		t_in      = 32'(tgt_rd) < 32'(n_eff);
		t_self    = 32'(tgt_rd) == 32'(i_q);
		last_node = (i_q + NCW'(1)) == n_eff;
		last_init = 32'(i_q) == MAX_NODES - 1;
		mag       = s_q[63] ? (64'd0 - s_q) : s_q;
		gain      = $signed({17'd0, nwc_q}) - $signed({1'b0, md_rsp.q});
		off_clip  = (32'(off_rd) > MAX_EDGES) ? ECW'(MAX_EDGES) : ECW'(off_rd);
		// modularity from the divider, with sign and saturation
		if (s_q[63]) qv = lmp_pkg::QW'(-$signed({1'b0, md_rsp.q[33:0]}));
		else if (md_rsp.q[33]) qv = lmp_pkg::Q_MAX;
		else qv = $signed(md_rsp.q[33:0]);
		dq   = {{2{qv[33]}}, qv} - {{2{qcur_q[33]}}, qcur_q};
		cont = (moves_q != '0) && (dq > $signed({4'd0, min_imp_q}));
		sw_n = sw_q + SWW'(1);
		impd = {qnow_q[33], qnow_q} - {qstart_q[33], qstart_q};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lmp_pkg::ST_IDLE: begin
				if (accept && kind == lmp_pkg::KIND_RUN) state_d = lmp_pkg::ST_INIT;
				else if (accept && kind == lmp_pkg::KIND_LABEL) state_d = lmp_pkg::ST_LBL;
			end
			lmp_pkg::ST_LBL:  state_d = lmp_pkg::ST_IDLE;
			lmp_pkg::ST_INIT: if (last_init) state_d = lmp_pkg::ST_EA;
			lmp_pkg::ST_SD_W: state_d = last_node ? lmp_pkg::ST_MD_L : lmp_pkg::ST_EA;
			lmp_pkg::ST_EA:   state_d = lmp_pkg::ST_EB;
			lmp_pkg::ST_EB:   state_d = lmp_pkg::ST_EC;
			lmp_pkg::ST_EC:   state_d = lmp_pkg::ST_EL;
			lmp_pkg::ST_EL: begin
				if (e_q < end_q) state_d = lmp_pkg::ST_ED;
				else state_d = gather_q ? lmp_pkg::ST_RM_A : lmp_pkg::ST_SD_W;
			end
			lmp_pkg::ST_ED: begin
				if (gather_q && t_in && !t_self) state_d = lmp_pkg::ST_GC;
				else state_d = lmp_pkg::ST_EL;
			end
			lmp_pkg::ST_GC:    state_d = lmp_pkg::ST_GS;
			lmp_pkg::ST_GS:    state_d = lmp_pkg::ST_EL;
			lmp_pkg::ST_CL_A:  state_d = (k_q < cnt_q) ? lmp_pkg::ST_CL_B : lmp_pkg::ST_OWN_A;
			lmp_pkg::ST_CL_B:  state_d = lmp_pkg::ST_CL_A;
			lmp_pkg::ST_OWN_A: state_d = lmp_pkg::ST_OWN_B;
			lmp_pkg::ST_OWN_B: state_d = lmp_pkg::ST_EA;
			lmp_pkg::ST_RM_A:  state_d = lmp_pkg::ST_RM_B;
			lmp_pkg::ST_RM_B:  state_d = lmp_pkg::ST_EV_A;
			lmp_pkg::ST_EV_A:  state_d = (k_q < cnt_q) ? lmp_pkg::ST_EV_B : lmp_pkg::ST_INS_A;
			lmp_pkg::ST_EV_B:  state_d = lmp_pkg::ST_EV_C;
			lmp_pkg::ST_EV_C:  state_d = lmp_pkg::ST_EV_D;
			lmp_pkg::ST_EV_D:  if (md_rsp.done) state_d = lmp_pkg::ST_EV_A;
			lmp_pkg::ST_INS_A: state_d = lmp_pkg::ST_INS_B;
			lmp_pkg::ST_INS_B: state_d = last_node ? lmp_pkg::ST_MD_L : lmp_pkg::ST_CL_A;
			lmp_pkg::ST_SW:    state_d = lmp_pkg::ST_CL_A;
			lmp_pkg::ST_MD_L:  state_d = (k_q < n_eff) ? lmp_pkg::ST_MD_B : lmp_pkg::ST_MD_Q;
			lmp_pkg::ST_MD_B:  state_d = (ctot_rd != 48'd0) ? lmp_pkg::ST_MD_C : lmp_pkg::ST_MD_L;
			lmp_pkg::ST_MD_C:  if (md_rsp.done) state_d = lmp_pkg::ST_MD_L;
			lmp_pkg::ST_MD_Q:  state_d = lmp_pkg::ST_MD_R;
			lmp_pkg::ST_MD_R: begin
				if (md_rsp.done) begin
					if (!phase_q) state_d = lmp_pkg::ST_SW;
					else if (!cont || 32'(sw_n) >= MAX_SWEEPS) state_d = lmp_pkg::ST_DONE;
					else state_d = lmp_pkg::ST_SW;
				end
			end
			lmp_pkg::ST_DONE: state_d = lmp_pkg::ST_IDLE;
			default:          state_d = lmp_pkg::ST_IDLE;
		endcase
	end

	// memory ports and unit requests
	always_comb begin
		off_we = accept && kind == lmp_pkg::KIND_OFFSET && 32'(slot) <= MAX_NODES;
		off_wa = NCW'(slot);
		off_wd = offset_value;
		off_ra = (state_q == lmp_pkg::ST_EB) ? i_q + NCW'(1) : i_q;
		edg_we = accept && kind == lmp_pkg::KIND_EDGE && 32'(slot) < MAX_EDGES;
		edg_wa = EW'(slot);
		edg_ra = e_q[EW-1:0];

		comm_we = 1'b0;
		comm_wa = i_q[NW-1:0];
		comm_wd = best_q;
		comm_ra = NW'(slot);
		cin_we  = 1'b0;
		cin_wa  = i_q[NW-1:0];
		cin_wd  = 48'd0;
		cin_ra  = k_q[NW-1:0];
		ctot_we = 1'b0;
		ctot_wa = i_q[NW-1:0];
		ctot_wd = 48'd0;
		ctot_ra = k_q[NW-1:0];
		ds_we   = 1'b0;
		nw_we   = 1'b0;
		nw_wa   = i_q[NW-1:0];
		nw_wd   = 48'd0;
		nw_ra   = own_q;
		seen_we = 1'b0;
		seen_wa = i_q[NW-1:0];
		seen_wd = 1'b0;
		seen_ra = comm_rd;
		list_we = 1'b0;
		list_wa = cnt_q[NW-1:0];
		list_wd = c_q;
		list_ra = k_q[NW-1:0];

		md_req.go  = 1'b0;
		md_req.a   = {16'd0, ctot_rd};
		md_req.b   = ctot_rd;
		md_req.d   = m2;
		md_req.cap = lmp_pkg::CAP_TOT2;

		case (state_q)
			lmp_pkg::ST_INIT: begin
				comm_we = 1'b1;
				comm_wd = i_q[NW-1:0];
				cin_we  = 1'b1;
				ctot_we = 1'b1;
				nw_we   = 1'b1;
				seen_we = 1'b1;
			end
			lmp_pkg::ST_SD_W: begin
				cin_we  = 1'b1;
				cin_wd  = {16'd0, self_q};
				ctot_we = 1'b1;
				ctot_wd = deg_q;
				ds_we   = 1'b1;
			end
			lmp_pkg::ST_ED:    comm_ra = NW'(tgt_rd);
			lmp_pkg::ST_GC:    nw_ra = comm_rd;
			lmp_pkg::ST_GS: begin
				nw_we   = 1'b1;
				nw_wa   = c_q;
				nw_wd   = seen_rd ? nw_rd + {16'd0, w_q} : {16'd0, w_q};
				seen_we = !seen_rd;
				seen_wa = c_q;
				seen_wd = 1'b1;
				list_we = !seen_rd;
			end
			lmp_pkg::ST_CL_B: begin
				nw_we   = 1'b1;
				nw_wa   = list_rd;
				seen_we = 1'b1;
				seen_wa = list_rd;
			end
			lmp_pkg::ST_OWN_A: comm_ra = i_q[NW-1:0];
			lmp_pkg::ST_OWN_B: begin
				list_we = 1'b1;
				list_wa = '0;
				list_wd = comm_rd;
				seen_we = 1'b1;
				seen_wa = comm_rd;
				seen_wd = 1'b1;
				nw_we   = 1'b1;
				nw_wa   = comm_rd;
			end
			lmp_pkg::ST_RM_A: begin
				cin_ra  = own_q;
				ctot_ra = own_q;
			end
			lmp_pkg::ST_RM_B: begin
				// take the node out of its community
				cin_we  = 1'b1;
				cin_wa  = own_q;
				cin_wd  = cin_rd - ({nw_rd[46:0], 1'b0} + {16'd0, self_rd});
				ctot_we = 1'b1;
				ctot_wa = own_q;
				ctot_wd = ctot_rd - deg_rd;
			end
			lmp_pkg::ST_EV_B: begin
				ctot_ra = list_rd;
				nw_ra   = list_rd;
			end
			lmp_pkg::ST_EV_C: begin
				md_req.go  = 1'b1;
				md_req.b   = deg_q;
				md_req.cap = lmp_pkg::CAP_GAIN;
			end
			lmp_pkg::ST_INS_A: begin
				cin_ra  = best_q;
				ctot_ra = best_q;
			end
			lmp_pkg::ST_INS_B: begin
				// insert the node into the best community
				cin_we  = 1'b1;
				cin_wa  = best_q;
				cin_wd  = cin_rd + {bw_q[46:0], 1'b0} + {16'd0, self_q};
				ctot_we = 1'b1;
				ctot_wa = best_q;
				ctot_wd = ctot_rd + deg_q;
				comm_we = 1'b1;
			end
			lmp_pkg::ST_MD_B:  md_req.go = ctot_rd != 48'd0;
			lmp_pkg::ST_MD_Q: begin
				md_req.go  = 1'b1;
				md_req.a   = mag;
				md_req.b   = lmp_pkg::SCALE_Q;
				md_req.cap = lmp_pkg::CAP_Q;
			end
			default: ;
		endcase
	end

	// graph store
	always_ff @(posedge clk) begin
		if (off_we) off_mem[off_wa] <= off_wd;
		off_rd <= off_mem[off_ra];
	end

	always_ff @(posedge clk) begin
		if (edg_we) begin
			tgt_mem[edg_wa] <= neighbor;
			wgt_mem[edg_wa] <= edge_weight;
		end
		tgt_rd <= tgt_mem[edg_ra];
		wgt_rd <= wgt_mem[edg_ra];
	end

	// community state
	always_ff @(posedge clk) begin
		if (comm_we) comm_mem[comm_wa] <= comm_wd;
		comm_rd <= comm_mem[comm_ra];
	end

	always_ff @(posedge clk) begin
		if (cin_we) cin_mem[cin_wa] <= cin_wd;
		cin_rd <= cin_mem[cin_ra];
	end

	always_ff @(posedge clk) begin
		if (ctot_we) ctot_mem[ctot_wa] <= ctot_wd;
		ctot_rd <= ctot_mem[ctot_ra];
	end

	always_ff @(posedge clk) begin
		if (ds_we) begin
			deg_mem[i_q[NW-1:0]]  <= deg_q;
			self_mem[i_q[NW-1:0]] <= self_q;
		end
		deg_rd  <= deg_mem[i_q[NW-1:0]];
		self_rd <= self_mem[i_q[NW-1:0]];
	end

	// neighbor-community scratch
	always_ff @(posedge clk) begin
		if (nw_we) nw_mem[nw_wa] <= nw_wd;
		nw_rd <= nw_mem[nw_ra];
	end

	always_ff @(posedge clk) begin
		if (seen_we) seen_mem[seen_wa] <= seen_wd;
		seen_rd <= seen_mem[seen_ra];
	end

	always_ff @(posedge clk) begin
		if (list_we) list_mem[list_wa] <= list_wd;
		list_rd <= list_mem[list_ra];
	end

	lmp_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 11'd1;
			total_wt_q   <= 48'd1;
			min_imp_q    <= 32'd0;
			weighted_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				lmp_pkg::REG_NODE_COUNT: node_count_q <= cfg_wdata[10:0];
				lmp_pkg::REG_TOTAL_WT:   total_wt_q   <= cfg_wdata;
				lmp_pkg::REG_MIN_IMP:    min_imp_q    <= cfg_wdata[31:0];
				lmp_pkg::REG_WEIGHTED:   weighted_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lmp_pkg::ST_IDLE;
			i_q      <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			moves_q  <= '0;
			sw_q     <= '0;
			gather_q <= 1'b0;
			found_q  <= 1'b0;
			phase_q  <= 1'b0;
			limit_q  <= 1'b0;
			ran_q    <= 1'b0;
			lbl_ok_q <= 1'b0;
			e_q      <= '0;
			end_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				lmp_pkg::ST_IDLE: begin
					if (accept) begin
						lbl_ok_q   <= 32'(slot) < MAX_NODES;
						lbl_slot_q <= slot[9:0];
						i_q        <= '0;
					end
				end
				lmp_pkg::ST_INIT: begin
					ran_q    <= 1'b1;
					cnt_q    <= '0;
					gather_q <= 1'b0;
					sw_q     <= '0;
					limit_q  <= 1'b0;
					i_q      <= last_init ? '0 : i_q + NCW'(1);
				end
				lmp_pkg::ST_SD_W: begin
					i_q     <= i_q + NCW'(1);
					k_q     <= '0;
					s_q     <= '0;
					phase_q <= 1'b0;
				end
				lmp_pkg::ST_EA: begin
					deg_q   <= '0;
					self_q  <= '0;
					found_q <= 1'b0;
				end
				lmp_pkg::ST_EB: e_q   <= ECW'(off_rd);
				lmp_pkg::ST_EC: end_q <= off_clip;
				lmp_pkg::ST_ED: begin
					w_q <= wv;
					if (!gather_q || !t_in || t_self) e_q <= e_q + ECW'(1);
					// degree and first self-loop during seeding
					if (!gather_q && t_in) begin
						deg_q <= deg_q + {16'd0, wv};
						if (t_self && !found_q) begin
							self_q  <= wv;
							found_q <= 1'b1;
						end
					end
				end
				lmp_pkg::ST_GC: c_q <= comm_rd;
				lmp_pkg::ST_GS: begin
					e_q <= e_q + ECW'(1);
					if (!seen_rd) cnt_q <= cnt_q + NCW'(1);
				end
				lmp_pkg::ST_CL_B: k_q <= k_q + NCW'(1);
				lmp_pkg::ST_OWN_B: begin
					own_q    <= comm_rd;
					cnt_q    <= NCW'(1);
					gather_q <= 1'b1;
				end
				lmp_pkg::ST_RM_B: begin
					deg_q  <= deg_rd;
					self_q <= self_rd;
					k_q    <= '0;
					bg_q   <= '0;
					best_q <= own_q;
					bw_q   <= '0;
				end
				lmp_pkg::ST_EV_B: c_q   <= list_rd;
				lmp_pkg::ST_EV_C: nwc_q <= nw_rd;
				lmp_pkg::ST_EV_D: begin
					if (md_rsp.done) begin
						k_q <= k_q + NCW'(1);
						if (gain > bg_q) begin
							bg_q   <= gain;
							best_q <= c_q;
							bw_q   <= nwc_q;
						end
					end
				end
				lmp_pkg::ST_INS_B: begin
					if (best_q != own_q) moves_q <= moves_q + NCW'(1);
					i_q     <= i_q + NCW'(1);
					k_q     <= '0;
					s_q     <= '0;
					phase_q <= 1'b1;
				end
				lmp_pkg::ST_SW: begin
					qcur_q  <= qnow_q;
					moves_q <= '0;
					i_q     <= '0;
					k_q     <= '0;
				end
				lmp_pkg::ST_MD_B: begin
					cin_q <= cin_rd;
					if (ctot_rd == 48'd0) k_q <= k_q + NCW'(1);
				end
				lmp_pkg::ST_MD_C: begin
					if (md_rsp.done) begin
						s_q <= s_q + {{16{cin_q[47]}}, cin_q} - md_rsp.q;
						k_q <= k_q + NCW'(1);
					end
				end
				lmp_pkg::ST_MD_R: begin
					if (md_rsp.done) begin
						qnow_q <= qv;
						if (!phase_q) qstart_q <= qv;
						else begin
							sw_q <= sw_n;
							if (cont && 32'(sw_n) >= MAX_SWEEPS) limit_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == lmp_pkg::ST_LBL) begin
				done_q       <= 1'b1;
				rkind_q      <= lmp_pkg::RPT_LABEL;
				moves_out_q  <= '0;
				sweeps_out_q <= '0;
				imp_q        <= '0;
				limit_out_q  <= 1'b0;
				if (!lbl_ok_q) label_q <= '0;
				else if (!ran_q) label_q <= lbl_slot_q;
				else label_q <= 10'(comm_rd);
			end else if (state_q == lmp_pkg::ST_DONE) begin
				done_q       <= 1'b1;
				rkind_q      <= lmp_pkg::RPT_PASS;
				label_q      <= '0;
				moves_out_q  <= 11'(moves_q);
				sweeps_out_q <= 7'(sw_q);
				limit_out_q  <= limit_q;
				if (impd[34] != impd[33]) imp_q <= impd[34] ? lmp_pkg::Q_MIN : lmp_pkg::Q_MAX;
				else imp_q <= impd[33:0];
			end
		end
	end

	assign done             = done_q;
	assign report_kind      = rkind_q;
	assign label            = label_q;
	assign moves_last_sweep = moves_out_q;
	assign sweeps           = sweeps_out_q;
	assign improvement      = imp_q;
	assign sweep_limit_hit  = limit_out_q;

`ifndef NO_ASSERTIONS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a preceding busy cycle");
	a_md_inside_run: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.busy |-> busy) else $error("arithmetic unit active while idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_NODES) else $error("candidate list overflow");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for louvain_local_moving_pass_core: loads small CSR graphs,
// runs passes and reads labels under random start gaps, checking every report.
// Depends on lmp_pkg and the core RTL.
module tb_top;
	import lmp_pkg::*;

	localparam int  N_MAX      = 1024;
	localparam int  E_MAX      = 8192;
	localparam int  SWEEP_MAX  = 64;
	localparam int  ITEM_GOAL  = 1100;
	localparam int  CYCLE_CAP  = 20000000;
	localparam int  IDLE_GAP   = 8;
	localparam longint QSAT_HI = 64'sd8589934591;
	localparam longint QSAT_LO = -64'sd8589934592;

	typedef struct {
		logic [1:0]  kind;
		logic [12:0] slot;
		logic [13:0] offv;
		logic [9:0]  nbr;
		logic [31:0] wt;
	} cmd_t;

	typedef struct {
		logic        rk;
		logic [9:0]  lbl;
		logic [10:0] moves;
		logic [6:0]  swp;
		logic [33:0] imp;
		logic        lim;
	} report_t;

	logic clk, arst_n, start, busy;
	logic [1:0]  kind;
	logic [12:0] slot;
	logic [13:0] offset_value;
	logic [9:0]  neighbor;
	logic [31:0] edge_weight;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_wdata;
	logic        done, report_kind, sweep_limit_hit;
	logic [9:0]  label;
	logic [10:0] moves_last_sweep;
	logic [6:0]  sweeps;
	logic signed [33:0] improvement;

	louvain_local_moving_pass_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .slot(slot), .offset_value(offset_value), .neighbor(neighbor),
		.edge_weight(edge_weight), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .report_kind(report_kind), .label(label),
		.moves_last_sweep(moves_last_sweep), .sweeps(sweeps), .improvement(improvement),
		.sweep_limit_hit(sweep_limit_hit)
	);

	cmd_t    pend_cmds[$];
	report_t want_reports[$];
	int      errors, cycles, items_sent;
	bit      calm;
	int      gap_left;

	// Mirror of the configuration registers
	logic [10:0] m_nodes;
	logic [47:0] m_m2;
	logic [31:0] m_minimp;
	logic        m_wmode;

	// Mirror of the graph store and the community state
	logic [13:0]    g_off[0:N_MAX];
	logic [9:0]     g_tgt[0:E_MAX-1];
	logic [31:0]    g_wt[0:E_MAX-1];
	logic [9:0]     comm[0:N_MAX-1];
	longint         cin[0:N_MAX-1];
	longint unsigned ctot[0:N_MAX-1], ndeg[0:N_MAX-1], nself[0:N_MAX-1];
	longint unsigned ncw[0:N_MAX-1];
	bit             seen[0:N_MAX-1];
	int             clist[0:N_MAX-1];

	// Scratch for graph generation
	logic [13:0] s_off[0:N_MAX];
	logic [9:0]  s_tgt[0:E_MAX-1];
	logic [31:0] s_wt[0:E_MAX-1];

	function automatic longint unsigned div_cap(longint unsigned a, longint unsigned b,
			longint unsigned d, longint unsigned cap);
		logic [127:0] p, q;
		p = {64'd0, a} * {64'd0, b};
		q = p / {64'd0, d};
		return (q >= {64'd0, cap}) ? cap : q[63:0];
	endfunction

	function automatic longint wrap48(logic [63:0] v);
		return {{16{v[47]}}, v[47:0]};
	endfunction

	function automatic longint unsigned edge_wt(int e);
		return m_wmode ? longint'(g_wt[e]) : 64'd65536;
	endfunction

	function automatic int edge_stop(int v);
		return (g_off[v+1] > E_MAX) ? E_MAX : int'(g_off[v+1]);
	endfunction

	// Modularity in Q1.32 of the current partition
	function automatic longint modularity(int n, longint unsigned m2);
		longint s;
		longint unsigned mag, q;
		s = 0;
		for (int c = 0; c < n; c++)
			if (ctot[c] != 0)
				s += cin[c] - longint'(div_cap(ctot[c], ctot[c], m2, CAP_TOT2));
		mag = (s < 0) ? longint'(-s) : s;
		q = div_cap(mag, 64'h1_0000_0000, m2, CAP_Q);
		if (s < 0)
			return -longint'(q);
		return (q > QSAT_HI) ? QSAT_HI : longint'(q);
	endfunction

	// Collect neighbor-community weights of node v, own community first
	function automatic int gather_nbrs(int v, int n);
		int cnt, t, c;
		for (int k = 0; k < N_MAX; k++) begin
			seen[k] = 0;
			ncw[k] = 0;
		end
		clist[0] = comm[v];
		seen[comm[v]] = 1;
		cnt = 1;
		for (int e = g_off[v]; e < edge_stop(v); e++) begin
			t = g_tgt[e];
			if (t >= n || t == v)
				continue;
			c = comm[t];
			if (!seen[c]) begin
				clist[cnt] = c;
				seen[c] = 1;
				cnt++;
			end
			ncw[c] += edge_wt(e);
		end
		return cnt;
	endfunction

	// One full local-moving pass on the mirrored graph
	function automatic report_t run_pass();
		report_t r;
		int n, cnt, old, best, moves, swp;
		longint unsigned m2, dg, bw;
		longint q0, qprev, qnow, bg, g, imp;
		bit found, lim;
		n = (m_nodes == 0) ? 1 : ((m_nodes > N_MAX) ? N_MAX : int'(m_nodes));
		m2 = (m_m2 == 0) ? 1 : m_m2;
		for (int i = 0; i < N_MAX; i++) begin
			comm[i] = i;
			cin[i] = 0;
			ctot[i] = 0;
			ndeg[i] = 0;
			nself[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			found = 0;
			for (int e = g_off[i]; e < edge_stop(i); e++) begin
				if (g_tgt[e] >= n)
					continue;
				ndeg[i] += edge_wt(e);
				if (g_tgt[e] == i && !found) begin
					nself[i] = edge_wt(e);
					found = 1;
				end
			end
			cin[i] = wrap48(nself[i]);
			ctot[i] = ndeg[i];
		end
		q0 = modularity(n, m2);
		qnow = q0;
		swp = 0;
		lim = 0;
		moves = 0;
		while (1) begin
			qprev = qnow;
			moves = 0;
			for (int i = 0; i < n; i++) begin
				old = comm[i];
				best = old;
				bw = 0;
				bg = 0;
				dg = ndeg[i];
				cnt = gather_nbrs(i, n);
				cin[old] = wrap48(cin[old] - (2 * ncw[old] + nself[i]));
				ctot[old] -= dg;
				for (int k = 0; k < cnt; k++) begin
					g = longint'(ncw[clist[k]])
						- longint'(div_cap(ctot[clist[k]], dg, m2, CAP_GAIN));
					if (g > bg) begin
						bg = g;
						best = clist[k];
						bw = ncw[clist[k]];
					end
				end
				cin[best] = wrap48(cin[best] + 2 * bw + nself[i]);
				ctot[best] += dg;
				comm[i] = best;
				if (best != old)
					moves++;
			end
			qnow = modularity(n, m2);
			swp++;
			if (!(moves > 0 && qnow - qprev > longint'({32'd0, m_minimp})))
				break;
			if (swp >= SWEEP_MAX) begin
				lim = 1;
				break;
			end
		end
		imp = qnow - q0;
		if (imp > QSAT_HI) imp = QSAT_HI;
		if (imp < QSAT_LO) imp = QSAT_LO;
		r.rk = RPT_PASS;
		r.lbl = '0;
		r.moves = moves;
		r.swp = swp;
		r.imp = imp[33:0];
		r.lim = lim;
		return r;
	endfunction

	// Apply one accepted item to the mirror; queue any expected report
	function automatic void apply_item(cmd_t c);
		report_t r;
		case (c.kind)
			KIND_OFFSET: if (c.slot <= N_MAX) g_off[c.slot] = c.offv;
			KIND_EDGE: begin
				g_tgt[c.slot] = c.nbr;
				g_wt[c.slot] = c.wt;
			end
			KIND_RUN: want_reports.push_back(run_pass());
			default: begin
				r = '{RPT_LABEL, (c.slot < N_MAX) ? comm[c.slot] : 10'd0, 0, 0, 0, 0};
				want_reports.push_back(r);
			end
		endcase
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Item driver
	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		if (!arst_n) begin
			start <= 0;
			gap_left <= 0;
		end else if (start && busy) begin
			// hold the presented item
		end else begin
			if (start)
				apply_item('{kind, slot, offset_value, neighbor, edge_weight});
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 0;
			end else if (pend_cmds.size() > 0) begin
				c = pend_cmds.pop_front();
				kind <= c.kind;
				slot <= c.slot;
				offset_value <= c.offv;
				neighbor <= c.nbr;
				edge_weight <= c.wt;
				start <= 1;
				if (!calm && $urandom_range(0, 4) == 0)
					gap_left <= $urandom_range(1, 6);
			end else begin
				start <= 0;
			end
		end
	end

	// Report checker
	always @(posedge clk) begin
		report_t w;
		if (arst_n && done) begin
			if (want_reports.size() == 0) begin
				$display("%0t: unexpected report kind=%0d label=%0d", $time, report_kind, label);
				errors++;
			end else begin
				w = want_reports.pop_front();
				if (report_kind !== w.rk) begin
					$display("%0t: report_kind exp %0d got %0d", $time, w.rk, report_kind);
					errors++;
				end
				if (label !== w.lbl) begin
					$display("%0t: label exp %0d got %0d", $time, w.lbl, label);
					errors++;
				end
				if (moves_last_sweep !== w.moves) begin
					$display("%0t: moves exp %0d got %0d", $time, w.moves, moves_last_sweep);
					errors++;
				end
				if (sweeps !== w.swp) begin
					$display("%0t: sweeps exp %0d got %0d", $time, w.swp, sweeps);
					errors++;
				end
				if (improvement !== w.imp) begin
					$display("%0t: improvement exp %0d got %0d", $time,
						$signed(w.imp), improvement);
					errors++;
				end
				if (sweep_limit_hit !== w.lim) begin
					$display("%0t: limit exp %0d got %0d", $time, w.lim, sweep_limit_hit);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_cmd(logic [1:0] k, int s, int ov, int nb, logic [31:0] w);
		pend_cmds.push_back('{k, s[12:0], ov[13:0], nb[9:0], w});
		if (!(k == KIND_OFFSET && s > N_MAX))
			items_sent++;
	endtask

	// Wait until nothing is pending or in flight
	task automatic drain();
		while (pend_cmds.size() != 0 || start || busy || want_reports.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_NODE_COUNT: m_nodes = val[10:0];
			REG_TOTAL_WT:   m_m2 = val;
			REG_MIN_IMP:    m_minimp = val[31:0];
			default:        m_wmode = val[0];
		endcase
	endtask

	function automatic logic [31:0] rand_wt();
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return ($urandom_range(1, 8) << 16) + $urandom_range(0, 65535);
		endcase
	endfunction

	// Build a random graph, configure, load it, run and read labels
	task automatic graph_phase(int n, bit near_end, bit wmode, int mi_sel);
		int dg[0:N_MAX-1];
		bit rev[0:N_MAX-1];
		int total, base, stop_e, t;
		longint unsigned wsum;
		total = 0;
		for (int v = 0; v < n; v++) begin
			dg[v] = $urandom_range(0, 4);
			rev[v] = ($urandom_range(0, 7) == 0);
			if (!rev[v]) total += dg[v];
		end
		base = near_end ? E_MAX - total : $urandom_range(0, E_MAX - 1 - total);
		s_off[0] = base;
		for (int v = 0; v < n; v++)
			s_off[v+1] = rev[v] ? ((s_off[v] >= 2) ? s_off[v] - $urandom_range(1, 2) : s_off[v])
				: s_off[v] + dg[v];
		if (near_end && s_off[n] == E_MAX && $urandom_range(0, 1))
			s_off[n] = $urandom_range(E_MAX + 1, 16383);
		wsum = 0;
		for (int v = 0; v < n; v++) begin
			stop_e = (s_off[v+1] > E_MAX) ? E_MAX : s_off[v+1];
			for (int e = s_off[v]; e < stop_e; e++) begin
				case ($urandom_range(0, 9))
					0: t = v;
					1, 2: t = $urandom_range(0, 1023);
					3, 4: t = $urandom_range(0, n - 1);
					default: t = (v / 3) * 3 + $urandom_range(0, 2);
				endcase
				if (t >= n && $urandom_range(0, 1)) t = v;
				s_tgt[e] = t;
				s_wt[e] = rand_wt();
			end
		end
		// weighted degree sum of the graph as it will stand after loading
		for (int v = 0; v < n; v++) begin
			stop_e = (s_off[v+1] > E_MAX) ? E_MAX : s_off[v+1];
			for (int e = s_off[v]; e < stop_e; e++)
				if (s_tgt[e] < n) wsum += wmode ? longint'(s_wt[e]) : 64'd65536;
		end
		cfg_write(REG_NODE_COUNT, (n == 1 && $urandom_range(0, 1)) ? 0 : n);
		cfg_write(REG_WEIGHTED, wmode);
		case ($urandom_range(0, 9))
			0: cfg_write(REG_TOTAL_WT, {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF);
			1: cfg_write(REG_TOTAL_WT, 0);
			default: cfg_write(REG_TOTAL_WT, wsum[47:0]);
		endcase
		case (mi_sel)
			0: cfg_write(REG_MIN_IMP, 0);
			1: cfg_write(REG_MIN_IMP, $urandom_range(0, 32'h0100_0000));
			default: cfg_write(REG_MIN_IMP, 32'hFFFF_FFFF);
		endcase
		for (int v = 0; v <= n; v++)
			push_cmd(KIND_OFFSET, v, s_off[v], 0, 0);
		for (int v = 0; v < n; v++) begin
			stop_e = (s_off[v+1] > E_MAX) ? E_MAX : s_off[v+1];
			for (int e = s_off[v]; e < stop_e; e++)
				push_cmd(KIND_EDGE, e, 0, s_tgt[e], s_wt[e]);
			if ($urandom_range(0, 5) == 0)
				push_cmd(KIND_OFFSET, $urandom_range(N_MAX + 1, 8191), $urandom_range(0, 16383),
					0, 0);
		end
		push_cmd(KIND_RUN, $urandom_range(0, 8191), $urandom_range(0, 16383),
			$urandom_range(0, 1023), $urandom);
		repeat ($urandom_range(3, 8))
			push_cmd(KIND_LABEL, $urandom_range(0, n - 1), 0, 0, 0);
		push_cmd(KIND_LABEL, $urandom_range(0, 8191), $urandom_range(0, 16383),
			$urandom_range(0, 1023), $urandom);
		drain();
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		kind = KIND_OFFSET;
		slot = '0;
		offset_value = '0;
		neighbor = '0;
		edge_weight = '0;
		cfg_we = 0;
		cfg_index = REG_NODE_COUNT;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		items_sent = 0;
		calm = 0;
		m_nodes = 1;
		m_m2 = 1;
		m_minimp = 0;
		m_wmode = 1;
		for (int i = 0; i < N_MAX; i++) comm[i] = i;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// Directed: labels before any run, ignored and edge-extreme writes
		push_cmd(KIND_LABEL, 0, 0, 0, 0);
		push_cmd(KIND_LABEL, 1023, 0, 0, 0);
		push_cmd(KIND_LABEL, 1024, 0, 0, 0);
		push_cmd(KIND_LABEL, 8191, 16383, 1023, 32'hFFFF_FFFF);
		push_cmd(KIND_OFFSET, 1025, 16383, 0, 0);
		push_cmd(KIND_OFFSET, 8191, 16383, 0, 0);
		push_cmd(KIND_EDGE, 8191, 0, 1023, 32'hFFFF_FFFF);
		drain();

		// Directed: single node with a zero-weight self-loop, node_count 0 acts as 1
		cfg_write(REG_NODE_COUNT, 0);
		cfg_write(REG_TOTAL_WT, 0);
		push_cmd(KIND_OFFSET, 0, 0, 0, 0);
		push_cmd(KIND_OFFSET, 1, 1, 0, 0);
		push_cmd(KIND_EDGE, 0, 0, 0, 0);
		push_cmd(KIND_RUN, 0, 0, 0, 0);
		push_cmd(KIND_LABEL, 0, 0, 0, 0);
		push_cmd(KIND_LABEL, 5, 0, 0, 0);
		drain();

		// Directed: register extremes with label reads only
		cfg_write(REG_NODE_COUNT, 11'h7FF);
		cfg_write(REG_NODE_COUNT, N_MAX);
		cfg_write(REG_TOTAL_WT, 48'hFFFF_FFFF_FFFF);
		cfg_write(REG_MIN_IMP, 32'hFFFF_FFFF);
		cfg_write(REG_WEIGHTED, 0);
		push_cmd(KIND_LABEL, 3, 0, 0, 0);
		drain();

		// Directed: two graphs at the top of edge space (high threshold; unit weights), one lower
		graph_phase(8, 1, 1, 2);
		graph_phase(6, 1, 0, 0);
		graph_phase(12, 0, 1, 0);

		// Random graphs
		while (items_sent < ITEM_GOAL) begin
			calm = (items_sent > ITEM_GOAL * 85 / 100);
			graph_phase($urandom_range(1, 12), $urandom_range(0, 7) == 0,
				$urandom_range(0, 3) != 0, ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(0, 1));
		end
		drain();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
